[rtl/core/hsi2rgb_pkg.sv]
`default_nettype none

package hsi2rgb_pkg;

    // Fixed field widths of the pixel beats.
    localparam int SAT_W  = 9;
    localparam int INT_W  = 9;
    localparam int CHAN_W = 8;

    // Product of intensity and saturation fits in this many bits (511 * 256).
    localparam int IS_W = 17;

    // Scale of intensity times the 1/256 saturation step, before the hue fraction.
    localparam int SCALE_SHIFT = 16;

    // Saturation of one full unit; larger codes are clamped to it.
    localparam logic [SAT_W-1:0] FULL_SAT = 9'd256;

    // Largest channel code.
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Hue sectors, named after the color that starts and ends each one.
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

endpackage

`default_nettype wire

[rtl/core/hsi2rgb_round.sv]
`default_nettype none

module hsi2rgb_round #(
    parameter int HUE_BITS = 12
) (
    input  wire logic [hsi2rgb_pkg::IS_W+HUE_BITS-1:0] i_level,
    output logic [hsi2rgb_pkg::CHAN_W-1:0]             o_chan
);
    import hsi2rgb_pkg::*;

    localparam int VW = IS_W + HUE_BITS;
    localparam int FS = SCALE_SHIFT + HUE_BITS;
    localparam int SW = VW + CHAN_W;
    localparam logic [SW-1:0] HALF = SW'(1) << (FS - 1);

    logic [SW-1:0] w_scaled;
    logic [SW-FS-1:0] w_quot;

    // Level times 255 is a shift and a subtract, then round half up.
    always_comb begin
        w_scaled = ({i_level, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, i_level}) + HALF;
        w_quot   = w_scaled[SW-1:FS];
    end

    // Levels above full scale saturate at the top code.
    assign o_chan = w_quot[SW-FS-1] ? CHAN_MAX : w_quot[CHAN_W-1:0];

endmodule

`default_nettype wire

[rtl/core/hsi_to_rgb_sector_converter.sv]
`default_nettype none

// HSI to RGB pixel converter.
// The slave channel takes one hue, saturation and intensity triple per beat;
// the master side returns one pixel of three 8-bit channels per beat, in the same order.
// Hue is a fraction of a turn in HUE_BITS bits; saturation and intensity run
// from 0 to 256 in steps of 1/256. Saturation above 256 is clamped; intensity
// above 256 is used as given and the channels saturate at 255.
// The datapath is a four-stage pipeline: sector split and intensity times
// saturation, the hue-offset multiply, the per-sector channel select, and the
// rounding into the output register. Each stage is registered, and one beat
// can be taken every cycle, since every stage hands its beat on at each edge
// it is not stalled. Each stage holds its beat while the next one is full and
// stalled, so a stall on the master side loses nothing. Bubbles inside the
// pipeline still let new beats in, so the slave side stays ready until every
// stage is full. Reset clears the valid bits of all stages, so no pixel is
// invented.
module hsi_to_rgb_sector_converter #(
    parameter int HUE_BITS = 12,
    localparam int IN_TDATA_W =
        ((HUE_BITS + hsi2rgb_pkg::SAT_W + hsi2rgb_pkg::INT_W + 7) / 8) * 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // hue_turn, saturation, intensity_level, zero fill
    input  wire logic [IN_TDATA_W-1:0]              i_s_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // red_out, green_out, blue_out
    output logic [3*hsi2rgb_pkg::CHAN_W-1:0]        o_m_tdata
);
    import hsi2rgb_pkg::*;

    localparam int VW = IS_W + HUE_BITS;
    localparam int H6_W = HUE_BITS + 3;

    // Input fields.
    logic [HUE_BITS-1:0] w_hue;
    logic [SAT_W-1:0]    w_sat;
    logic [INT_W-1:0]    w_int;
    logic [SAT_W-1:0]    w_sat_c;
    logic [H6_W-1:0]     w_h6;
    logic [SAT_W+INT_W-1:0] w_is_full;

    assign w_hue = i_s_tdata[HUE_BITS-1:0];
    assign w_sat = i_s_tdata[HUE_BITS+SAT_W-1:HUE_BITS];
    assign w_int = i_s_tdata[HUE_BITS+SAT_W+INT_W-1:HUE_BITS+SAT_W];

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic w_en1, w_en2, w_en3, w_en4;

    // Stage registers.
    logic                r1_v;
    t_sector             r1_sector;
    logic [HUE_BITS-1:0] r1_off;
    logic [INT_W-1:0]    r1_int;
    logic [IS_W-1:0]     r1_is;

    logic                r2_v;
    t_sector             r2_sector;
    logic [IS_W-1:0]     r2_top;
    logic [IS_W-1:0]     r2_low;
    logic [VW-1:0]       r2_prod;

    logic                r3_v;
    logic [VW-1:0]       r3_r;
    logic [VW-1:0]       r3_g;
    logic [VW-1:0]       r3_b;

    logic                r4_v;
    logic [3*CHAN_W-1:0] r4_data;

    // Next values.
    logic [IS_W-1:0] n_top;
    logic [VW-1:0]   n_prod;
    logic [VW-1:0]   w_top_l, w_low_l, w_rise, w_fall;
    logic [VW-1:0]   n_r, n_g, n_b;
    logic [CHAN_W-1:0] w_red, w_green, w_blue;

    // Ready chain from the output back to the input.
    always_comb begin
        w_en4 = !r4_v || i_m_tready;
        w_en3 = !r3_v || w_en4;
        w_en2 = !r2_v || w_en3;
        w_en1 = !r1_v || w_en2;
    end

    assign o_s_tready = w_en1;
    assign o_m_tvalid = r4_v;
    assign o_m_tdata  = r4_data;

    // Valid bits travel with the beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_s_tvalid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= r3_v;
        end
    end

    // Stage 1: clamp saturation, split hue times six, intensity times saturation.
    always_comb begin
        w_sat_c   = (w_sat > FULL_SAT) ? FULL_SAT : w_sat;
        w_h6      = {1'b0, w_hue, 2'b00} + {2'b00, w_hue, 1'b0};
        w_is_full = w_int * w_sat_c;
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_sector <= t_sector'(w_h6[H6_W-1:HUE_BITS]);
            r1_off    <= w_h6[HUE_BITS-1:0];
            r1_int    <= w_int;
            r1_is     <= w_is_full[IS_W-1:0];
        end
    end

    // Stage 2: full and low levels, and the ramp span times the hue offset.
    always_comb begin
        n_top  = {r1_int, 8'h00};
        n_prod = r1_is * r1_off;
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_sector <= r1_sector;
            r2_top    <= n_top;
            r2_low    <= n_top - r1_is;
            r2_prod   <= n_prod;
        end
    end

    // Stage 3: form the two ramps and route levels by sector.
    always_comb begin
        w_top_l = {r2_top, {HUE_BITS{1'b0}}};
        w_low_l = {r2_low, {HUE_BITS{1'b0}}};
        w_rise  = w_low_l + r2_prod;
        w_fall  = w_top_l - r2_prod;
        case (r2_sector)
            SEC_RY: begin
                n_r = w_top_l; n_g = w_rise;  n_b = w_low_l;
            end
            SEC_YG: begin
                n_r = w_fall;  n_g = w_top_l; n_b = w_low_l;
            end
            SEC_GC: begin
                n_r = w_low_l; n_g = w_top_l; n_b = w_rise;
            end
            SEC_CB: begin
                n_r = w_low_l; n_g = w_fall;  n_b = w_top_l;
            end
            SEC_BM: begin
                n_r = w_rise;  n_g = w_low_l; n_b = w_top_l;
            end
            default: begin
                n_r = w_top_l; n_g = w_low_l; n_b = w_fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_r <= n_r;
            r3_g <= n_g;
            r3_b <= n_b;
        end
    end

    // Stage 4: round each channel to a byte into the output register.
    hsi2rgb_round #(.HUE_BITS(HUE_BITS)) u_round_r (.i_level(r3_r), .o_chan(w_red));
    hsi2rgb_round #(.HUE_BITS(HUE_BITS)) u_round_g (.i_level(r3_g), .o_chan(w_green));
    hsi2rgb_round #(.HUE_BITS(HUE_BITS)) u_round_b (.i_level(r3_b), .o_chan(w_blue));

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_data <= {w_blue, w_green, w_red};
        end
    end

    // The low level never rises above the full level.
    a_low_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v |-> (r2_low <= r2_top))
        else $error("low level above full level in stage 2");

    // A middle stage blocked by its successor keeps its beat.
    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && !w_en3) |=> (r2_v && $stable(r2_prod) && $stable(r2_top)))
        else $error("stage 2 beat changed while stalled");

    // An empty first stage always takes a new beat.
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r1_v |-> o_s_tready)
        else $error("input not ready although stage 1 is empty");

endmodule

`default_nettype wire

[bench/hsi_pixel_checker.sv]
`timescale 1ns / 100ps

// Scoreboard for the HSI to RGB converter. It watches both stream channels,
// predicts one RGB pixel per accepted input beat and compares each output beat
// with the oldest predicted pixel.
module hsi_pixel_checker #(
    parameter int HUE_BITS = 12,
    localparam int IN_W =
        ((HUE_BITS + hsi2rgb_pkg::SAT_W + hsi2rgb_pkg::INT_W + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             i_s_tready,
    // hue_turn, saturation, intensity_level, zero fill
    input  wire logic [IN_W-1:0]                  i_s_tdata,
    input  wire logic                             i_m_tvalid,
    input  wire logic                             i_m_tready,
    // red_out, green_out, blue_out
    input  wire logic [3*hsi2rgb_pkg::CHAN_W-1:0] i_m_tdata,
    output int                                    o_fail_count,
    output int                                    o_pixels_pending,
    output int                                    o_beats_taken,
    output int                                    o_pixels_checked
);
    import hsi2rgb_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb_pixel;

    localparam int LEVEL_SHIFT = SCALE_SHIFT + HUE_BITS;

    t_rgb_pixel expected_pixels[$];

    // A level in units of 2^-(16+HUE_BITS) of full scale becomes a byte,
    // rounded half up and clamped at the top.
    function automatic logic [CHAN_W-1:0] level_to_byte(input logic [63:0] level);
        logic [63:0] scaled;
        scaled = (level * 64'd255 + (64'd1 << (LEVEL_SHIFT - 1))) >> LEVEL_SHIFT;
        return (scaled > 64'(CHAN_MAX)) ? CHAN_MAX : scaled[CHAN_W-1:0];
    endfunction

    // One pixel from one hue, saturation and intensity triple.
    function automatic t_rgb_pixel predict_pixel(
        input logic [HUE_BITS-1:0] hue,
        input logic [SAT_W-1:0]    sat_code,
        input logic [INT_W-1:0]    lvl_code
    );
        logic [63:0] sat, lvl, h6, off, top, low, rise, fall, r, g, b;
        t_sector     sector;
        t_rgb_pixel  px;
        sat  = (sat_code > FULL_SAT) ? 64'(FULL_SAT) : 64'(sat_code);
        lvl  = 64'(lvl_code);
        h6   = 64'(hue) * 64'd6;
        sector = t_sector'(h6[HUE_BITS+2:HUE_BITS]);
        off  = h6 & ((64'd1 << HUE_BITS) - 64'd1);
        top  = (lvl * 64'd256) << HUE_BITS;
        low  = (lvl * (64'd256 - sat)) << HUE_BITS;
        rise = low + lvl * sat * off;
        fall = top - lvl * sat * off;
        case (sector)
            SEC_RY: begin r = top;  g = rise; b = low;  end
            SEC_YG: begin r = fall; g = top;  b = low;  end
            SEC_GC: begin r = low;  g = top;  b = rise; end
            SEC_CB: begin r = low;  g = fall; b = top;  end
            SEC_BM: begin r = rise; g = low;  b = top;  end
            default: begin r = top; g = low;  b = fall; end
        endcase
        px.red   = level_to_byte(r);
        px.green = level_to_byte(g);
        px.blue  = level_to_byte(b);
        return px;
    endfunction

    // Output beats are compared before the input beat of the same edge is
    // queued; the pipeline never returns a pixel in the cycle it takes it.
    always @(posedge i_clk) begin
        t_rgb_pixel got, want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_rgb_pixel'(i_m_tdata);
                if (expected_pixels.size() == 0) begin
                    $error("Pixel beat %h with no pixel expected", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    o_pixels_checked++;
                    if (got.red !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, got.red);
                        o_fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, got.green);
                        o_fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_pixels.push_back(predict_pixel(
                    i_s_tdata[HUE_BITS-1:0],
                    i_s_tdata[HUE_BITS+SAT_W-1:HUE_BITS],
                    i_s_tdata[HUE_BITS+SAT_W+INT_W-1:HUE_BITS+SAT_W]));
                o_beats_taken++;
            end
            o_pixels_pending = expected_pixels.size();
        end
    end

endmodule

[bench/hsi_to_rgb_sector_converter_test.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the HSI to RGB converter.
module hsi_to_rgb_sector_converter_test;
    import hsi2rgb_pkg::*;

    localparam int HUE_BITS    = 12;
    localparam int IN_W        = ((HUE_BITS + SAT_W + INT_W + 7) / 8) * 8;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // hue_turn, saturation, intensity_level, zero fill
    logic [IN_W-1:0]       i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // red_out, green_out, blue_out
    logic [3*CHAN_W-1:0]   o_m_tdata;

    int fail_count, pixels_pending, beats_taken, pixels_checked;
    int tx_idle_pct, rx_idle_pct;
    bit rx_hold_req;
    bit rx_hold_done;
    int rx_hold_left;

    hsi_to_rgb_sector_converter #(.HUE_BITS(HUE_BITS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    hsi_pixel_checker #(.HUE_BITS(HUE_BITS)) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .o_fail_count     (fail_count),
        .o_pixels_pending (pixels_pending),
        .o_beats_taken    (beats_taken),
        .o_pixels_checked (pixels_checked)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run time guard.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Pixel receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        i_m_tready   = 1'b0;
        rx_hold_left = 0;
        rx_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                i_m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offers one triple, with a random gap in front, and returns at the
    // falling edge after the beat is taken.
    task automatic send_triple(
        input logic [HUE_BITS-1:0] hue,
        input logic [SAT_W-1:0]    sat,
        input logic [INT_W-1:0]    lvl
    );
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= IN_W'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'({lvl, sat, hue});
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Random triple; most stay in the nominal range, some use the whole code.
    task automatic send_random_triple();
        logic [HUE_BITS-1:0] hue;
        logic [SAT_W-1:0]    sat;
        logic [INT_W-1:0]    lvl;
        hue = HUE_BITS'($urandom);
        case ($urandom_range(9))
            0:       begin sat = '0;                  lvl = INT_W'($urandom_range(256)); end
            1:       begin sat = SAT_W'($urandom);    lvl = '0;                          end
            2, 3:    begin sat = SAT_W'($urandom);    lvl = INT_W'($urandom);            end
            4:       begin sat = FULL_SAT;            lvl = INT_W'($urandom_range(256)); end
            default: begin
                sat = SAT_W'($urandom_range(256));
                lvl = INT_W'($urandom_range(256));
            end
        endcase
        send_triple(hue, sat, lvl);
    endtask

    initial begin
        int sector_starts[5] = '{683, 1366, 2048, 2731, 3414};
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        rx_hold_req = 1'b0;
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, grey, black, clamping and sector edges.
        send_triple(12'd0,    FULL_SAT, 9'd256);
        send_triple(12'd0,    9'd0,     9'd0);
        send_triple(12'd4095, 9'd511,   9'd511);
        send_triple(12'd2222, 9'd300,   9'd0);
        send_triple(12'd1000, 9'd0,     9'd128);
        send_triple(12'd3000, 9'd0,     9'd256);
        send_triple(12'd500,  9'd511,   9'd200);
        send_triple(12'd1500, 9'd257,   9'd100);
        send_triple(12'd2500, 9'd128,   9'd511);
        send_triple(12'd3500, 9'd64,    9'd257);
        send_triple(12'd4095, 9'd1,     9'd1);
        foreach (sector_starts[k]) begin
            send_triple(HUE_BITS'(sector_starts[k] - 1), 9'd200, 9'd180);
            send_triple(HUE_BITS'(sector_starts[k]),     9'd200, 9'd180);
        end
        send_triple(12'd4000, FULL_SAT, 9'd256);
        send_triple(12'd341,  FULL_SAT, 9'd256);

        // Random with idling on both sides.
        repeat (600) send_random_triple();

        // Back to back with no idling at all.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (300) send_random_triple();

        // Long receiver hold-off while the sender keeps offering.
        rx_hold_req = 1'b1;
        repeat (200) send_random_triple();

        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        repeat (800) send_random_triple();

        i_s_tvalid <= 1'b0;
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d triples and %0d checked pixels: all sectors, black, grey,",
                 beats_taken, pixels_checked);
        $display("clamped codes, random stalls and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[hsi_to_rgb_sector_converter.f]
rtl/core/hsi2rgb_pkg.sv
rtl/core/hsi2rgb_round.sv
rtl/core/hsi_to_rgb_sector_converter.sv
bench/hsi_pixel_checker.sv
bench/hsi_to_rgb_sector_converter_test.sv
